>>> rtl/lzod_pkg.sv
// ----------------------------------------------------------------------------
// lzod_pkg
// Shared types, constants and helpers for the LZO1X stream decompressor.
// ----------------------------------------------------------------------------
package lzod_pkg;

  localparam int WINDOW_DEPTH_DEF = 65536;
  localparam int BURST_MAX_DEF    = 64;

  localparam int LEN_W  = 25;
  localparam int DIST_W = 17;

  localparam logic [LEN_W-1:0]  LEN_SAT    = 25'h1FF_FFFF;
  localparam logic [DIST_W-1:0] M2_OFFSET  = 17'h0_0800;
  localparam logic [DIST_W-1:0] M4_OFFSET  = 17'h0_4000;
  localparam logic [7:0]        FIRST_BIAS = 8'd17;
  localparam logic [7:0]        EXT_STEP   = 8'd255;
  localparam logic [LEN_W-1:0]  LIT_EXT_BASE = 25'd18;  // 15 + 3
  localparam logic [LEN_W-1:0]  M4_EXT_BASE  = 25'd9;   // 7 + 2
  localparam logic [LEN_W-1:0]  M3_EXT_BASE  = 25'd33;  // 31 + 2

  typedef enum logic [3:0] {
    PH_FIRST, PH_TOP, PH_AFTER_LIT, PH_AFTER_TRAIL, PH_LIT_EXT, PH_LIT,
    PH_TRAIL, PH_SHORT_DIST, PH_LONG_EXT, PH_DIST_LO, PH_DIST_HI, PH_COPY,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    STAT_RUN     = 3'd0,
    STAT_END     = 3'd1,
    STAT_UNDER   = 3'd2,
    STAT_OVER    = 3'd3,
    STAT_BADDIST = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FS_IDLE, FS_SETUP, FS_READ, FS_WRITE
  } fsm_t;

  localparam logic REG_CAPACITY = 1'b0;

  // Length add that sticks at the all-ones value.
  function automatic logic [LEN_W-1:0] sat_add(logic [LEN_W-1:0] a, logic [7:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {{(LEN_W-7){1'b0}}, b};
    return s[LEN_W] ? LEN_SAT : s[LEN_W-1:0];
  endfunction

endpackage

>>> rtl/lzod_ram.sv
// ----------------------------------------------------------------------------
// lzod_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lzod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lzo1x_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lzo1x_stream_decompressor
// LZO1X chunk decoder fed one compressed byte per request, with a history
// memory for match copies and bounds checks on distance and output size.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  in       in_valid / in_stall    in_kind, in_byte, in_last
//  out      out_valid / out_stall  out_has_byte, out_byte, out_run_last,
//                                  out_more_pending, out_status, out_count
//  cfg      psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// A literal, length, distance or idle request yields one result. A request
// that starts or continues a match copy goes through a setup state and then a
// read state and a write state per copied byte, up to BURST_MAX bytes: each
// byte is one read of the history memory and one write back at the output
// pointer. Reset is synchronous and clears all control state; the history
// memory is not cleared, since a match never reaches an entry that was not
// written. A new request is taken only when the block is idle and the output
// register is empty or its result leaves in the same cycle; a stalled output
// holds the copy loop in its write state.
//
module lzo1x_stream_decompressor
  import lzod_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int BURST_MAX    = BURST_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // compressed input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  // decoded output
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_has_byte,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_more_pending,
  output logic [2:0]        out_status,
  output logic [LEN_W-1:0]  out_count,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int SW = ((AW > DIST_W) ? AW : DIST_W) + 1;
  localparam int BW = $clog2(BURST_MAX + 1);
  localparam logic [17:0]      WIN_LIMIT = 18'(WINDOW_DEPTH);
  localparam logic [AW-1:0]    WIN_LAST  = AW'(WINDOW_DEPTH - 1);
  localparam logic [LEN_W-1:0] BURST_LEN = LEN_W'(BURST_MAX);
  localparam logic [BW-1:0]    BURST_CNT = BW'(BURST_MAX);

  // Control and parser state.
  fsm_t              state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  status_t           status_r, status_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [LEN_W-1:0]  prod_r, prod_nxt;
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [1:0]        trail_r, trail_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic [7:0]        dlo_r, dlo_nxt;
  logic              doomed_r, doomed_nxt;
  logic              ended_r, ended_nxt;
  logic              is_m4_r, is_m4_nxt;
  logic              shift3_r, shift3_nxt;
  logic [BW-1:0]     burst_r, burst_nxt;
  logic              fin_more_r, fin_more_nxt;
  status_t           fin_stat_r, fin_stat_nxt;
  logic [LEN_W-1:0]  cap_r;

  // Output register.
  logic              ov_r, ov_nxt;
  logic              o_has_r, o_has_nxt;
  logic [7:0]        o_byte_r, o_byte_nxt;
  logic              o_last_r, o_last_nxt;
  logic              o_more_r, o_more_nxt;
  status_t           o_stat_r, o_stat_nxt;
  logic [LEN_W-1:0]  o_cnt_r, o_cnt_nxt;

  // History memory port.
  logic          ram_we, ram_re;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [AW-1:0] src_addr;

  logic out_free, in_accept;
  logic [LEN_W-1:0] prod_inc;
  logic [AW-1:0]    wptr_inc;
  logic [SW-1:0]    src_diff, src_wrap;

  // Match start operands shared by the short and long distance forms.
  logic [13:0]       dist_word;
  logic [DIST_W-1:0] d0, sm_d, short_d;
  logic              sm_bad, sm_over;

  assign out_free  = !ov_r || !out_stall;
  assign in_stall  = !(state_r == FS_IDLE && out_free);
  assign in_accept = in_valid && !in_stall;

  // Produced count and its position in the window move together; the
  // pointer restarts when the count itself wraps.
  assign prod_inc = prod_r + LEN_W'(1);
  assign wptr_inc = (prod_inc == '0 || wptr_r == WIN_LAST) ? '0 : wptr_r + AW'(1);

  // Source of a copy: the output pointer minus the distance, modulo window.
  assign src_diff = SW'(wptr_r) - SW'(dist_r);
  assign src_wrap = src_diff[SW-1] ? src_diff + SW'(WINDOW_DEPTH) : src_diff;
  assign src_addr = src_wrap[AW-1:0];

  assign dist_word = {in_byte, dlo_r[7:2]};
  assign d0        = dist_r + {3'b0, dist_word};
  assign short_d   = dist_r + (shift3_r ? {6'b0, in_byte, 3'b0} : {7'b0, in_byte, 2'b0});
  always_comb begin
    if (phase_r == PH_SHORT_DIST) begin
      sm_d = short_d;
    end else if (is_m4_r) begin
      sm_d = d0 + M4_OFFSET;
    end else begin
      sm_d = {3'b0, dist_word} + DIST_W'(1);
    end
  end
  assign sm_bad  = (sm_d == '0) || ({8'b0, sm_d} > prod_r) || ({1'b0, sm_d} > WIN_LIMIT);
  assign sm_over = ({1'b0, prod_r} + {1'b0, len_r}) > {1'b0, cap_r};

  assign ram_wdata = (state_r == FS_WRITE) ? ram_rdata : in_byte;

  lzod_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (src_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FS_IDLE;
      phase_r    <= PH_FIRST;
      status_r   <= STAT_RUN;
      len_r      <= '0;
      dist_r     <= '0;
      prod_r     <= '0;
      wptr_r     <= '0;
      trail_r    <= '0;
      prev_r     <= '0;
      dlo_r      <= '0;
      doomed_r   <= 1'b0;
      ended_r    <= 1'b0;
      is_m4_r    <= 1'b0;
      shift3_r   <= 1'b0;
      burst_r    <= '0;
      fin_more_r <= 1'b0;
      fin_stat_r <= STAT_RUN;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      status_r   <= status_nxt;
      len_r      <= len_nxt;
      dist_r     <= dist_nxt;
      prod_r     <= prod_nxt;
      wptr_r     <= wptr_nxt;
      trail_r    <= trail_nxt;
      prev_r     <= prev_nxt;
      dlo_r      <= dlo_nxt;
      doomed_r   <= doomed_nxt;
      ended_r    <= ended_nxt;
      is_m4_r    <= is_m4_nxt;
      shift3_r   <= shift3_nxt;
      burst_r    <= burst_nxt;
      fin_more_r <= fin_more_nxt;
      fin_stat_r <= fin_stat_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_has_r  <= o_has_nxt;
    o_byte_r <= o_byte_nxt;
    o_last_r <= o_last_nxt;
    o_more_r <= o_more_nxt;
    o_stat_r <= o_stat_nxt;
    o_cnt_r  <= o_cnt_nxt;
  end

  // Capacity register; the user must write it only while the decoder is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      cap_r <= pwdata[LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-LEN_W){1'b0}}, cap_r} : '0;

  always_comb begin
    logic do_ins;
    logic lit_emit;
    logic [LEN_W-1:0] lit_n;
    logic [LEN_W-1:0] len_dec;

    state_nxt    = state_r;
    phase_nxt    = phase_r;
    status_nxt   = status_r;
    len_nxt      = len_r;
    dist_nxt     = dist_r;
    prod_nxt     = prod_r;
    wptr_nxt     = wptr_r;
    trail_nxt    = trail_r;
    prev_nxt     = prev_r;
    dlo_nxt      = dlo_r;
    doomed_nxt   = doomed_r;
    ended_nxt    = ended_r;
    is_m4_nxt    = is_m4_r;
    shift3_nxt   = shift3_r;
    burst_nxt    = burst_r;
    fin_more_nxt = fin_more_r;
    fin_stat_nxt = fin_stat_r;
    ov_nxt       = ov_r && out_stall;
    o_has_nxt    = o_has_r;
    o_byte_nxt   = o_byte_r;
    o_last_nxt   = o_last_r;
    o_more_nxt   = o_more_r;
    o_stat_nxt   = o_stat_r;
    o_cnt_nxt    = o_cnt_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    do_ins       = 1'b0;
    lit_emit     = 1'b0;
    lit_n        = '0;
    len_dec      = len_r - LEN_W'(1);

    unique case (state_r)
      FS_IDLE: begin
        if (in_accept) begin
          if (phase_r == PH_COPY) begin
            // A pending copy takes any request as a continue.
            state_nxt = FS_SETUP;
          end else begin
            if (phase_r != PH_DONE && !in_kind) begin
              ended_nxt = ended_r | in_last;
              prev_nxt  = in_byte;
              unique case (phase_r) inside
                PH_FIRST: begin
                  if (in_byte > FIRST_BIAS) begin
                    lit_n      = LEN_W'(in_byte - FIRST_BIAS);
                    len_nxt    = lit_n;
                    doomed_nxt = ({1'b0, prod_r} + {1'b0, lit_n}) > {1'b0, cap_r};
                    phase_nxt  = (lit_n < LEN_W'(4)) ? PH_TRAIL : PH_LIT;
                  end else begin
                    do_ins = 1'b1;
                  end
                end
                PH_TOP, PH_AFTER_LIT, PH_AFTER_TRAIL: begin
                  do_ins = 1'b1;
                end
                PH_LIT_EXT: begin
                  if (in_byte == 8'd0) begin
                    len_nxt = sat_add(len_r, EXT_STEP);
                  end else begin
                    lit_n      = sat_add(len_r, in_byte);
                    len_nxt    = lit_n;
                    doomed_nxt = ({1'b0, prod_r} + {1'b0, lit_n}) > {1'b0, cap_r};
                    phase_nxt  = PH_LIT;
                  end
                end
                PH_LIT, PH_TRAIL: begin
                  if (!doomed_r) begin
                    lit_emit = 1'b1;
                    ram_we   = 1'b1;
                    prod_nxt = prod_inc;
                    wptr_nxt = wptr_inc;
                  end
                  if (len_r != '0) begin
                    len_nxt = len_dec;
                  end
                  if (len_r == '0 || len_dec == '0) begin
                    if (doomed_r) begin
                      status_nxt = STAT_OVER;
                      phase_nxt  = PH_DONE;
                    end else begin
                      phase_nxt = (phase_r == PH_LIT) ? PH_AFTER_LIT : PH_AFTER_TRAIL;
                    end
                  end
                end
                PH_LONG_EXT: begin
                  len_nxt = sat_add(len_r, (in_byte == 8'd0) ? EXT_STEP : in_byte);
                  if (in_byte != 8'd0) begin
                    phase_nxt = PH_DIST_LO;
                  end
                end
                PH_DIST_LO: begin
                  dlo_nxt   = in_byte;
                  phase_nxt = PH_DIST_HI;
                end
                PH_SHORT_DIST, PH_DIST_HI: begin
                  if (phase_r == PH_DIST_HI && is_m4_r && d0 == '0) begin
                    // End of stream marker.
                    status_nxt = STAT_END;
                    phase_nxt  = PH_DONE;
                  end else if (sm_bad) begin
                    status_nxt = STAT_BADDIST;
                    phase_nxt  = PH_DONE;
                  end else if (sm_over) begin
                    status_nxt = STAT_OVER;
                    phase_nxt  = PH_DONE;
                  end else begin
                    dist_nxt  = sm_d;
                    trail_nxt = prev_r[1:0];
                    phase_nxt = PH_COPY;
                  end
                end
                default: begin
                  status_nxt = STAT_UNDER;
                  phase_nxt  = PH_DONE;
                end
              endcase

              if (do_ins) begin
                if (in_byte >= 8'd64) begin
                  dist_nxt   = DIST_W'(in_byte[4:2]) + DIST_W'(1);
                  shift3_nxt = 1'b1;
                  len_nxt    = LEN_W'(in_byte[7:5]) + LEN_W'(1);
                  phase_nxt  = PH_SHORT_DIST;
                end else if (in_byte >= 8'd16) begin
                  is_m4_nxt = (in_byte < 8'd32);
                  if (in_byte < 8'd32) begin
                    dist_nxt = in_byte[3] ? M4_OFFSET : '0;
                    len_nxt  = (in_byte[2:0] != '0) ? LEN_W'(in_byte[2:0]) + LEN_W'(2)
                                                    : M4_EXT_BASE;
                    phase_nxt = (in_byte[2:0] != '0) ? PH_DIST_LO : PH_LONG_EXT;
                  end else begin
                    dist_nxt = DIST_W'(1);
                    len_nxt  = (in_byte[4:0] != '0) ? LEN_W'(in_byte[4:0]) + LEN_W'(2)
                                                    : M3_EXT_BASE;
                    phase_nxt = (in_byte[4:0] != '0) ? PH_DIST_LO : PH_LONG_EXT;
                  end
                end else if (phase_r == PH_FIRST || phase_r == PH_TOP) begin
                  if (in_byte == 8'd0) begin
                    len_nxt   = LIT_EXT_BASE;
                    phase_nxt = PH_LIT_EXT;
                  end else begin
                    lit_n      = LEN_W'(in_byte) + LEN_W'(3);
                    len_nxt    = lit_n;
                    doomed_nxt = ({1'b0, prod_r} + {1'b0, lit_n}) > {1'b0, cap_r};
                    phase_nxt  = PH_LIT;
                  end
                end else begin
                  // Short match right after a literal run or trailing literals.
                  dist_nxt   = DIST_W'(in_byte[7:2]) + DIST_W'(1) +
                               ((phase_r == PH_AFTER_LIT) ? M2_OFFSET : '0);
                  shift3_nxt = 1'b0;
                  len_nxt    = (phase_r == PH_AFTER_LIT) ? LEN_W'(3) : LEN_W'(2);
                  phase_nxt  = PH_SHORT_DIST;
                end
              end
            end

            // Input ran out while the decoder still needs bytes.
            if (ended_nxt && phase_nxt != PH_COPY && phase_nxt != PH_DONE) begin
              status_nxt = STAT_UNDER;
              phase_nxt  = PH_DONE;
            end

            if (phase_nxt == PH_COPY) begin
              state_nxt = FS_SETUP;
            end else begin
              ov_nxt     = 1'b1;
              o_has_nxt  = lit_emit;
              o_byte_nxt = lit_emit ? in_byte : 8'd0;
              o_last_nxt = 1'b1;
              o_more_nxt = 1'b0;
              o_stat_nxt = status_nxt;
              o_cnt_nxt  = prod_nxt;
            end
          end
        end
      end

      FS_SETUP: begin
        // Size this burst and settle the flags every result of it carries.
        fin_more_nxt = (len_r > BURST_LEN);
        burst_nxt    = (len_r > BURST_LEN) ? BURST_CNT : len_r[BW-1:0];
        fin_stat_nxt = (len_r <= BURST_LEN && ended_r) ? STAT_UNDER : status_r;
        state_nxt    = FS_READ;
      end

      FS_READ: begin
        ram_re    = 1'b1;
        state_nxt = FS_WRITE;
      end

      FS_WRITE: begin
        if (out_free) begin
          ram_we     = 1'b1;
          prod_nxt   = prod_inc;
          wptr_nxt   = wptr_inc;
          len_nxt    = len_dec;
          burst_nxt  = burst_r - BW'(1);
          ov_nxt     = 1'b1;
          o_has_nxt  = 1'b1;
          o_byte_nxt = ram_rdata;
          o_last_nxt = (burst_r == BW'(1));
          o_more_nxt = fin_more_r;
          o_stat_nxt = fin_stat_r;
          o_cnt_nxt  = prod_inc;
          if (burst_r == BW'(1)) begin
            state_nxt = FS_IDLE;
            if (len_dec == '0) begin
              if (trail_r != '0) begin
                len_nxt    = LEN_W'(trail_r);
                doomed_nxt = ({1'b0, prod_inc} + {1'b0, LEN_W'(trail_r)}) > {1'b0, cap_r};
                phase_nxt  = PH_TRAIL;
              end else begin
                phase_nxt = PH_TOP;
              end
              if (ended_r) begin
                status_nxt = STAT_UNDER;
                phase_nxt  = PH_DONE;
              end
            end
          end else begin
            state_nxt = FS_READ;
          end
        end
      end

      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  assign out_valid        = ov_r;
  assign out_has_byte     = o_has_r;
  assign out_byte         = o_byte_r;
  assign out_run_last     = o_last_r;
  assign out_more_pending = o_more_r;
  assign out_status       = o_stat_r;
  assign out_count        = o_cnt_r;

endmodule

>>> test/lzo1x_stream_decompressor_tb.sv
// ----------------------------------------------------------------------------
// lzo1x_stream_decompressor_tb
// Self-checking testbench for the LZO1X stream decompressor. It builds
// well-formed compressed chunks from random literal runs and M1 to M4 matches
// and decodes every accepted request in a local decoder model. Each result is
// then checked field by field against the queue of predicted results.
// ----------------------------------------------------------------------------
module lzo1x_stream_decompressor_tb
  import lzod_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN   = WINDOW_DEPTH_DEF;
  localparam int BURST = BURST_MAX_DEF;
  localparam int LIMIT = 2000000;

  // One request on the input channel.
  typedef struct {
    bit         kind;
    logic [7:0] byt;
    bit         last;
  } req_t;

  // One predicted result on the output channel.
  typedef struct {
    bit              has;
    logic [7:0]      byt;
    bit              run_last;
    bit              more;
    logic [2:0]      stat;
    logic [LEN_W-1:0] cnt;
  } result_t;

  // Where the chunk builder stands in the LZO grammar.
  typedef enum {G_TOP, G_LIT, G_TRAIL} grammar_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_has_byte;
  logic [7:0] out_byte;
  logic out_run_last;
  logic out_more_pending;
  logic [2:0] out_status;
  logic [LEN_W-1:0] out_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;

  lzo1x_stream_decompressor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_has_byte(out_has_byte),
    .out_byte(out_byte), .out_run_last(out_run_last),
    .out_more_pending(out_more_pending), .out_status(out_status),
    .out_count(out_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  req_t    feed_q[$];      // compressed requests waiting for the driver
  result_t decoded_q[$];   // predicted results, oldest first

  int tx_idle = 28;
  int rx_idle = 57;
  int n_fed = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_bytes = 0;
  int mismatches = 0;
  int cycles = 0;
  bit in_acc = 1'b0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_cnt = 0;

  // --------------------------------------------------------------------------
  // Decoder model. It mirrors the block's parsing state, its history window
  // and its capacity register, and turns each accepted request into the list
  // of results that the block must return for it.
  // --------------------------------------------------------------------------
  logic [7:0]       hist [WIN];
  phase_t           ph = PH_FIRST;
  status_t          st = STAT_RUN;
  logic [LEN_W-1:0] len_c = '0;
  logic [LEN_W-1:0] prod = '0;
  logic [LEN_W-1:0] cap = '0;
  logic [DIST_W-1:0] mdist = '0;
  logic [1:0]       trail = '0;
  logic [7:0]       prev = '0;
  logic [7:0]       dist_low = '0;
  int unsigned      shift = 2;
  bit               doomed = 0;
  bit               ended = 0;
  bit               is_m4 = 0;
  logic [7:0]       burst_b [BURST];
  logic [LEN_W-1:0] burst_c [BURST];
  int               nres;

  function automatic logic [LEN_W-1:0] len_plus(logic [LEN_W-1:0] a, int unsigned b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + (LEN_W+1)'(b);
    return s > {1'b0, LEN_SAT} ? LEN_SAT : s[LEN_W-1:0];
  endfunction

  function void stop_on(status_t code);
    st = code;
    ph = PH_DONE;
  endfunction

  function void put_out(logic [7:0] v);
    hist[prod % WIN] = v;
    prod = prod + 1'b1;
    if (nres < BURST) begin
      burst_b[nres] = v;
      burst_c[nres] = prod;
      nres++;
    end
  endfunction

  function void open_literals(logic [LEN_W-1:0] n, phase_t p);
    len_c = n;
    doomed = ({1'b0, prod} + {1'b0, n}) > {1'b0, cap};
    ph = p;
  endfunction

  function void copy_some();
    while (len_c != 0 && nres < BURST) begin
      put_out(hist[32'(prod - mdist) % WIN]);
      len_c--;
    end
    if (len_c == 0) begin
      if (trail != 0) open_literals(LEN_W'(trail), PH_TRAIL);
      else ph = PH_TOP;
    end
  endfunction

  function void open_match(int unsigned d, logic [LEN_W-1:0] n, logic [7:0] prior);
    if (d == 0 || d > prod || d > WIN) begin
      stop_on(STAT_BADDIST);
      return;
    end
    if (({1'b0, prod} + {1'b0, n}) > {1'b0, cap}) begin
      stop_on(STAT_OVER);
      return;
    end
    mdist = DIST_W'(d);
    len_c = n;
    trail = prior[1:0];
    ph = PH_COPY;
    copy_some();
  endfunction

  function void parse_opcode(int unsigned b, phase_t p);
    int unsigned lf;
    if (b >= 64) begin
      mdist = DIST_W'(1 + ((b >> 2) & 7));
      shift = 3;
      len_c = LEN_W'((b >> 5) + 1);
      ph = PH_SHORT_DIST;
    end else if (b >= 16) begin
      is_m4 = b < 32;
      if (is_m4) begin
        mdist = DIST_W'((b & 8) << 11);
        lf = b & 7;
        len_c = lf != 0 ? LEN_W'(lf + 2) : M4_EXT_BASE;
      end else begin
        mdist = DIST_W'(1);
        lf = b & 31;
        len_c = lf != 0 ? LEN_W'(lf + 2) : M3_EXT_BASE;
      end
      ph = lf != 0 ? PH_DIST_LO : PH_LONG_EXT;
    end else if (p == PH_TOP) begin
      if (b == 0) begin
        len_c = LIT_EXT_BASE;
        ph = PH_LIT_EXT;
      end else begin
        open_literals(LEN_W'(b + 3), PH_LIT);
      end
    end else begin
      mdist = DIST_W'(1 + (b >> 2) + (p == PH_AFTER_LIT ? 32'(M2_OFFSET) : 0));
      shift = 2;
      len_c = p == PH_AFTER_LIT ? LEN_W'(3) : LEN_W'(2);
      ph = PH_SHORT_DIST;
    end
  endfunction

  function void take_compressed(logic [7:0] b);
    logic [7:0] prior;
    int unsigned w, d0;
    prior = prev;
    prev = b;
    case (ph)
      PH_FIRST: begin
        if (b > FIRST_BIAS) begin
          if (b - FIRST_BIAS < 4) open_literals(LEN_W'(b - FIRST_BIAS), PH_TRAIL);
          else open_literals(LEN_W'(b - FIRST_BIAS), PH_LIT);
        end else begin
          parse_opcode(b, PH_TOP);
        end
      end
      PH_TOP, PH_AFTER_LIT, PH_AFTER_TRAIL: parse_opcode(b, ph);
      PH_LIT_EXT: begin
        if (b == 0) len_c = len_plus(len_c, 255);
        else open_literals(len_plus(len_c, b), PH_LIT);
      end
      PH_LIT, PH_TRAIL: begin
        if (!doomed) put_out(b);
        if (len_c != 0) len_c--;
        if (len_c == 0) begin
          if (doomed) stop_on(STAT_OVER);
          else if (ph == PH_LIT) ph = PH_AFTER_LIT;
          else ph = PH_AFTER_TRAIL;
        end
      end
      PH_LONG_EXT: begin
        len_c = len_plus(len_c, b == 0 ? 255 : b);
        if (b != 0) ph = PH_DIST_LO;
      end
      PH_SHORT_DIST: open_match(mdist + (int'(b) << shift), len_c, prior);
      PH_DIST_LO: begin
        dist_low = b;
        ph = PH_DIST_HI;
      end
      PH_DIST_HI: begin
        w = (int'(dist_low) | (int'(b) << 8)) >> 2;
        if (is_m4) begin
          d0 = mdist + w;
          if (d0 == 0) begin
            st = STAT_END;
            ph = PH_DONE;
          end else begin
            open_match(d0 + 32'(M4_OFFSET), len_c, prior);
          end
        end else begin
          open_match(1 + w, len_c, prior);
        end
      end
      default: stop_on(STAT_UNDER);
    endcase
  endfunction

  // Works out every result of one accepted request and queues them.
  function void decode_request(bit kind, logic [7:0] b, bit last);
    result_t r;
    int n;
    bit more;
    nres = 0;
    if (ph == PH_COPY) begin
      copy_some();
    end else if (ph != PH_DONE && kind == 1'b0) begin
      if (last) ended = 1;
      take_compressed(b);
    end
    if (ended && ph != PH_COPY && ph != PH_DONE) stop_on(STAT_UNDER);
    more = ph == PH_COPY;
    n = nres > 0 ? nres : 1;
    for (int k = 0; k < n; k++) begin
      r.has = nres > 0;
      r.byt = nres > 0 ? burst_b[k] : 8'd0;
      r.run_last = k == n - 1;
      r.more = more;
      r.stat = st;
      r.cnt = nres > 0 ? burst_c[k] : prod;
      decoded_q.push_back(r);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Chunk builder. It tracks how many bytes the chunk has produced so far
  // (built_len) so that every match distance stays inside the written part
  // of the history, and it tracks which instruction forms are legal next.
  // --------------------------------------------------------------------------
  int unsigned built_len = 0;
  grammar_t    gram = G_TOP;

  function void feed(bit kind, int unsigned b, bit last);
    req_t r;
    r.kind = kind;
    r.byt = b[7:0];
    r.last = last;
    feed_q.push_back(r);
    n_fed++;
  endfunction

  function void feed_literals(int unsigned n);
    repeat (n) feed(0, $urandom_range(255), 0);
    built_len += n;
  endfunction

  // Length extension: runs of zero bytes worth 255 each, then a nonzero byte.
  function void feed_extension(int unsigned rem);
    int unsigned zeros, nz;
    zeros = rem / 255;
    nz = rem % 255;
    if (nz == 0) begin
      zeros--;
      nz = 255;
    end
    repeat (zeros) feed(0, 0, 0);
    feed(0, nz, 0);
  endfunction

  // Continue requests for the part of a copy past the first burst. Some of
  // them are stray compressed bytes, which the block must treat as continues.
  function void finish_copy(int unsigned len, int unsigned tr);
    int unsigned k;
    k = len > BURST ? (len - 1) / BURST : 0;
    repeat (k) begin
      if ($urandom_range(4) == 0) feed(0, $urandom_range(255), $urandom_range(1));
      else feed(1, $urandom_range(255), $urandom_range(1));
    end
    built_len += len;
    if (tr != 0) begin
      feed_literals(tr);
      gram = G_TRAIL;
    end else begin
      gram = G_TOP;
    end
  endfunction

  function void build_first(int unsigned n);
    feed(0, 17 + n, 0);
    feed_literals(n);
    gram = n < 4 ? G_TRAIL : G_LIT;
  endfunction

  function void build_litrun(int unsigned n);
    if (n <= 18) begin
      feed(0, n - 3, 0);
    end else begin
      feed(0, 0, 0);
      feed_extension(n - 18);
    end
    feed_literals(n);
    gram = G_LIT;
  endfunction

  // Short match after literals: length 3 with the 2 KiB offset, or length 2
  // after trailing literals.
  function void build_m1(int unsigned d, int unsigned tr);
    int unsigned w, len;
    if (gram == G_LIT) begin
      w = d - 2049;
      len = 3;
    end else begin
      w = d - 1;
      len = 2;
    end
    feed(0, ((w & 3) << 2) | tr, 0);
    feed(0, w >> 2, 0);
    finish_copy(len, tr);
  endfunction

  function void build_m2(int unsigned len, int unsigned d, int unsigned tr);
    feed(0, ((len - 1) << 5) | (((d - 1) & 7) << 2) | tr, 0);
    feed(0, (d - 1) >> 3, 0);
    finish_copy(len, tr);
  endfunction

  function void build_m3(int unsigned len, int unsigned d, int unsigned tr);
    if (len <= 33) begin
      feed(0, 32 | (len - 2), 0);
    end else begin
      feed(0, 32, 0);
      feed_extension(len - 33);
    end
    feed(0, (((d - 1) & 63) << 2) | tr, 0);
    feed(0, (d - 1) >> 6, 0);
    finish_copy(len, tr);
  endfunction

  function void build_m4(int unsigned len, int unsigned d, int unsigned tr);
    int unsigned e, h;
    e = d - 16384;
    h = e >= 16384 ? 8 : 0;
    if (h != 0) e -= 16384;
    if (len <= 9) begin
      feed(0, 16 | h | (len - 2), 0);
    end else begin
      feed(0, 16 | h, 0);
      feed_extension(len - 9);
    end
    feed(0, ((e & 63) << 2) | tr, 0);
    feed(0, e >> 6, 0);
    finish_copy(len, tr);
  endfunction

  function int unsigned near_dist(int unsigned hi);
    if (hi > built_len) hi = built_len;
    if ($urandom_range(1)) return $urandom_range(hi < 8 ? hi : 8, 1);
    return $urandom_range(hi, 1);
  endfunction

  function void build_random(int unsigned n);
    int unsigned first, r, len;
    first = n_fed;
    while (n_fed - first < n) begin
      r = $urandom_range(99);
      if (r < 6) begin
        feed(1, $urandom_range(255), $urandom_range(1));  // nothing pending
      end else if (gram == G_TOP && r < 35) begin
        build_litrun($urandom_range(4) == 0 ? $urandom_range(60, 19) : $urandom_range(18, 4));
      end else if (gram == G_TRAIL && r < 30) begin
        build_m1(near_dist(1024), $urandom_range(3));
      end else if (gram == G_LIT && r < 30 && built_len >= 2049) begin
        build_m1($urandom_range(built_len < 3072 ? built_len : 3072, 2049), $urandom_range(3));
      end else if (r < 55) begin
        build_m2($urandom_range(8, 3), near_dist(2048), $urandom_range(3));
      end else if (r < 85 || built_len < 16385) begin
        len = $urandom_range(9) == 0 ? $urandom_range(400, 41) : $urandom_range(40, 3);
        build_m3(len, near_dist(16384), $urandom_range(3));
      end else begin
        build_m4($urandom_range(30, 3),
                 $urandom_range(built_len < 49151 ? built_len : 49151, 16385),
                 $urandom_range(3));
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: offers the next pending request at the falling edge. A
  // request stays on the port unchanged until the block has taken it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    req_t r;
    if (rst_n && (!in_valid || in_acc)) begin
      if (feed_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
        r = feed_q.pop_front();
        in_kind <= r.kind;
        in_byte <= r.byt;
        in_last <= r.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random stalls, plus one long hold-off counted here that
  // lets the block fill up while the driver keeps offering requests.
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < rx_idle;
    end
  end

  // Checker and model update at the rising edge. A result can never leave
  // the block at the same edge its request goes in, so checking first is safe.
  always @(posedge clk) begin
    result_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycles,
               decoded_q.size());
      $display("FAILED: results differ");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: byte %0h count %0d status %0d",
                     out_byte, out_count, out_status);
        end else begin
          e = decoded_q.pop_front();
          n_checked++;
          if (e.has) n_bytes++;
          if (out_has_byte !== e.has || out_byte !== e.byt || out_run_last !== e.run_last ||
              out_more_pending !== e.more || out_status !== e.stat ||
              out_count !== e.cnt) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch at result %0d: has/byte/last/more/status/count ",
                        "expected %0b/%0h/%0b/%0b/%0d/%0d got %0b/%0h/%0b/%0b/%0d/%0d"},
                       n_checked, e.has, e.byt, e.run_last, e.more, e.stat, e.cnt,
                       out_has_byte, out_byte, out_run_last, out_more_pending,
                       out_status, out_count);
          end
        end
      end
      in_acc = in_valid && !in_stall;
      if (in_acc) begin
        decode_request(in_kind, in_byte, in_last);
        n_taken++;
      end
    end
  end

  // Register write with a setup and an access phase; the block is idle whenever this is called.
  task automatic write_capacity(logic [LEN_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap = v;
  endtask

  // Waits until every request has been taken and every result has come back,
  // then leaves a margin for the block to settle.
  task automatic drain();
    do @(negedge clk);
    while (n_taken != n_fed || decoded_q.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    int unsigned ending, d;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_capacity('0);
    write_capacity(25'd16777216);

    // Directed opening: the short first literal run that leaves the decoder
    // in the trailing-literal state, the M1, M2 and M3 match forms, literal runs with and
    // without extension, a copy spread over several continues, and an idle
    // continue.
    build_first(2);
    build_m1(near_dist(1024), 1);
    build_m2(8, 1, 0);
    build_litrun(5);
    build_m2(3, built_len, 3);
    build_m3(33, 1, 0);
    build_litrun(24);
    feed(1, 8'hFF, 1);
    build_m3(298, 2, 0);
    build_m2(4, built_len, 2);
    drain();

    // One long run-length copy grows the history past the M4 reach. The
    // receiver holds off for a while meanwhile, so the block backs up.
    hold_req = 1'b1;
    build_m3(33 + 64 * 255 + 100, near_dist(16384), 0);
    build_litrun(6);
    build_m1($urandom_range(3072, 2049), 2);
    build_m4(20, $urandom_range(built_len, 16385), 0);
    build_m4(5, built_len, 1);
    drain();

    write_capacity(25'(built_len + 200000 + $urandom_range(100000)));
    tx_idle = 57;
    rx_idle = 28;
    build_random(20);
    drain();

    write_capacity(25'd16777215);
    tx_idle = 0;
    rx_idle = 0;
    build_random(20);
    drain();

    // The chunk ends one of four ways; after that the block must only
    // repeat its status.
    ending = $urandom_range(3);
    if (ending == 2) begin
      write_capacity(25'(built_len + 1));
      if (gram == G_TOP) build_litrun(6);
      else build_m2(5, 1, 0);
    end else if (ending == 1) begin
      feed(0, 8'h60, 1);
    end else if (ending == 3 && built_len < 49151) begin
      d = built_len + 1;
      if (d <= 16384) build_m3(4, d, 0);
      else build_m4(4, d, 0);
    end else begin
      feed(0, 8'h11, 0);
      feed(0, 0, 0);
      feed(0, 0, 1);
    end
    repeat (4) feed($urandom_range(1), $urandom_range(255), $urandom_range(1));
    drain();
    repeat (200) @(negedge clk);

    $display("Covered %0d requests and %0d results (%0d decoded bytes).",
             n_taken, n_checked, n_bytes);
    $display("Chunk closed with status %s after %0d cycles, %0d mismatches.",
             st.name(), cycles, mismatches);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
